// ===== hdl/stable_min_priority_queue_defines.svh =====
// Assertion macros used by the priority queue top level.
`ifndef STABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SMPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smpq assertion failed");

// Next-cycle implication, disabled during reset.
`define SMPQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smpq assertion failed");

`endif

// ===== hdl/smpq_pkg.sv =====
// Types and constants of the stable minimum priority queue.
`timescale 1ns / 1ps

package smpq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int ID_W         = 8;
   localparam int PRIO_W       = 8;
   localparam int OCC_W        = 5;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Operation applied to the sorted store
   typedef struct packed {
      logic              insert;
      logic              remove;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } store_op_type;

   // Store status seen by the control stage
   typedef struct packed {
      logic              full;
      logic              empty;
      logic [ID_W-1:0]   head_id;
      logic [PRIO_W-1:0] head_prio;
   } store_stat_type;

endpackage

// ===== hdl/smpq_if.sv =====
// Request and response channel interfaces of the priority queue.
`timescale 1ns / 1ps

interface smpq_req_if import smpq_pkg::*; ();
   logic              valid;
   logic              ready;
   cmd_type           cmd;
   logic [ID_W-1:0]   item_id;
   logic [PRIO_W-1:0] item_priority;

   modport source (output valid, output cmd, output item_id, output item_priority,
                   input ready);
   modport sink   (input valid, input cmd, input item_id, input item_priority,
                   output ready);
endinterface

interface smpq_rsp_if import smpq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              out_valid;
   logic [ID_W-1:0]   out_id;
   logic [PRIO_W-1:0] out_priority;
   status_type        status;
   logic [OCC_W-1:0]  occupancy;

   modport source (output valid, output out_valid, output out_id, output out_priority,
                   output status, output occupancy, input ready);
   modport sink   (input valid, input out_valid, input out_id, input out_priority,
                   input status, input occupancy, output ready);
endinterface

// ===== hdl/smpq_store.sv =====
// Sorted shift-register store: ascending priority, oldest first among equals.
`timescale 1ns / 1ps

module smpq_store import smpq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int CNT_W   = $clog2(CAPACITY + 1),
   localparam int IDX_W   = $clog2(CAPACITY)
) (
   input  logic           clock,
   input  logic           reset,
   input  store_op_type   op,
   output store_stat_type stat,
   output logic [CNT_W-1:0] count
);

   // Cell 0 holds the next entry to leave; entries at or above count are don't-care.
   logic [ID_W-1:0]   id_ff   [CAPACITY];
   logic [PRIO_W-1:0] prio_ff [CAPACITY];
   logic [ID_W-1:0]   id_in   [CAPACITY];
   logic [PRIO_W-1:0] prio_in [CAPACITY];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CAPACITY-1:0] le;
   logic full, empty, do_ins, do_rem;

   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign do_ins = op.insert && !full;
   assign do_rem = op.remove && !empty;

   // Per-cell compare: valid entry whose priority is not above the new one
   always_comb begin
      for (int j = 0; j < CAPACITY; j++) begin
         le[j] = (CNT_W'(j) < count_ff) && (prio_ff[j] <= op.prio);
      end
   end

   // Per-cell next value: keep, take the new entry, shift up or shift down
   always_comb begin
      for (int j = 0; j < CAPACITY; j++) begin
         id_in[j]   = id_ff[j];
         prio_in[j] = prio_ff[j];
         if (do_ins) begin
            if (le[j]) begin
               id_in[j]   = id_ff[j];
               prio_in[j] = prio_ff[j];
            end else if (j == 0 || le[IDX_W'((j == 0) ? 0 : j - 1)]) begin
               id_in[j]   = op.id;
               prio_in[j] = op.prio;
            end else begin
               id_in[j]   = id_ff[IDX_W'((j == 0) ? 0 : j - 1)];
               prio_in[j] = prio_ff[IDX_W'((j == 0) ? 0 : j - 1)];
            end
         end else if (do_rem) begin
            id_in[j]   = id_ff[IDX_W'((j == CAPACITY - 1) ? j : j + 1)];
            prio_in[j] = prio_ff[IDX_W'((j == CAPACITY - 1) ? j : j + 1)];
         end
      end
   end

   // Entry count
   always_comb begin
      priority if (do_ins) begin
         count_in = count_ff + 1'b1;
      end else if (do_rem) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < CAPACITY; j++) begin
         id_ff[j]   <= id_in[j];
         prio_ff[j] <= prio_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.full      = full;
   assign stat.empty     = empty;
   assign stat.head_id   = id_ff[0];
   assign stat.head_prio = prio_ff[0];
   assign count          = count_ff;

endmodule

// ===== hdl/stable_min_priority_queue.sv =====
// Top level of the stable minimum priority queue.
//
//  channel   dir   handshake      payload
//  req_bus   in    valid/ready    cmd, item_id, item_priority
//  rsp_bus   out   valid/ready    out_valid, out_id, out_priority, status, occupancy
//
// One item per cycle sustained while results are taken; a result passes the input register, then the result register.
// The store updates all cells together: every cell compares with the new priority at once.
// Synchronous active-high reset empties the store; entry payload is not cleared.
// A stalled result holds the result register and then the input register; req_bus.ready
// drops only when both are full and the result is not taken.
`timescale 1ns / 1ps
`include "stable_min_priority_queue_defines.svh"

module stable_min_priority_queue import smpq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input logic       clock,
   input logic       reset,
   smpq_req_if.sink   req_bus,
   smpq_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef struct packed {
      cmd_type           cmd;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } req_item_type;

   typedef struct packed {
      logic              out_valid;
      logic [ID_W-1:0]   out_id;
      logic [PRIO_W-1:0] out_priority;
      status_type        status;
      logic [OCC_W-1:0]  occupancy;
   } rsp_item_type;

   logic           s1_valid_ff, s1_valid_in;
   req_item_type   s1_item_ff, s1_item_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_item_ff, rsp_item_in, result;
   logic           adv, req_take;
   store_op_type   op;
   store_stat_type stat;
   logic [CNT_W-1:0] count, count_next;

   // Handshake: the input stage moves on when the result register is free or drains
   assign adv      = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !s1_valid_ff || adv;

   // Store operation for the item in the input register
   assign op.insert = adv && (s1_item_ff.cmd == CMD_INSERT);
   assign op.remove = adv && (s1_item_ff.cmd == CMD_REMOVE);
   assign op.id     = s1_item_ff.id;
   assign op.prio   = s1_item_ff.prio;

   smpq_store #(.CAPACITY(CAPACITY)) u_store (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .stat  (stat),
      .count (count)
   );

   // Result of the item in the input register
   always_comb begin
      result     = '0;
      count_next = count;
      unique case (s1_item_ff.cmd)
         CMD_INSERT: begin
            if (stat.full) begin
               result.status = ST_FULL;
            end else begin
               result.status = ST_OK;
               count_next    = count + 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (stat.empty) begin
               result.status = ST_EMPTY;
            end else begin
               result.status       = ST_OK;
               result.out_valid    = 1'b1;
               result.out_id       = stat.head_id;
               result.out_priority = stat.head_prio;
               count_next          = count - 1'b1;
            end
         end
      endcase
      result.occupancy = OCC_W'(count_next);
   end

   // Next values of the input and result registers
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (adv) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = result;
         s1_valid_in  = 1'b0;
      end
      if (req_take) begin
         s1_valid_in     = 1'b1;
         s1_item_in.cmd  = req_bus.cmd;
         s1_item_in.id   = req_bus.item_id;
         s1_item_in.prio = req_bus.item_priority;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_valid    = rsp_item_ff.out_valid;
   assign rsp_bus.out_id       = rsp_item_ff.out_id;
   assign rsp_bus.out_priority = rsp_item_ff.out_priority;
   assign rsp_bus.status       = rsp_item_ff.status;
   assign rsp_bus.occupancy    = rsp_item_ff.occupancy;

   // Checks
   `SMPQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count <= CNT_W'(CAPACITY))
   `SMPQ_ASSERT_NXT(a_remove_count, clock, reset, op.remove && !stat.empty,
      count == CNT_W'($past(count) - 1'b1))
   `SMPQ_ASSERT_NXT(a_head_order, clock, reset, op.remove && (count > CNT_W'(1)),
      stat.head_prio >= $past(stat.head_prio))

endmodule

// ===== sim/stable_min_priority_queue_tb.sv =====
// Self-checking testbench of the stable minimum priority queue.
`timescale 1ns / 1ps

module stable_min_priority_queue_tb;
   import smpq_pkg::*;

   localparam int QUEUE_DEPTH = CAPACITY_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;

   // One result as the block should report it
   typedef struct packed {
      logic              out_valid;
      logic [ID_W-1:0]   out_id;
      logic [PRIO_W-1:0] out_priority;
      status_type        status;
      logic [OCC_W-1:0]  occupancy;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset;

   smpq_req_if req_bus ();
   smpq_rsp_if rsp_bus ();

   stable_min_priority_queue #(
      .CAPACITY(QUEUE_DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   // Shadow copy of the sorted store: descending priority, newest first among ties
   logic [ID_W-1:0]   held_ids   [QUEUE_DEPTH];
   logic [PRIO_W-1:0] held_prios [QUEUE_DEPTH];
   int                held_count = 0;

   queue_result_type awaited_results[$];
   int               mismatch_count = 0;
   int               idle_cycles    = 0;
   bit               req_idle_on    = 1'b1;
   bit               rsp_idle_on    = 1'b1;
   bit               req_offering   = 1'b0;
   int               rsp_hold_cycles = 0;

   // Apply one command to the shadow store and return what the block must answer
   function automatic queue_result_type predict_step(cmd_type op, logic [ID_W-1:0] id,
                                                     logic [PRIO_W-1:0] prio);
      queue_result_type r;
      int pos;
      r.out_valid    = 1'b0;
      r.out_id       = '0;
      r.out_priority = '0;
      r.status       = ST_OK;
      pos = 0;
      if (op == CMD_INSERT) begin
         if (held_count >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            while (pos < held_count && held_prios[pos] > prio) pos++;
            for (int k = held_count; k > pos; k--) begin
               held_ids[k]   = held_ids[k-1];
               held_prios[k] = held_prios[k-1];
            end
            held_ids[pos]   = id;
            held_prios[pos] = prio;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            held_count--;
            r.out_valid    = 1'b1;
            r.out_id       = held_ids[held_count];
            r.out_priority = held_prios[held_count];
         end
      end
      r.occupancy = OCC_W'(held_count);
      return r;
   endfunction

   // Offer one item, with an optional random gap first; returns once it is taken
   task automatic send_item(cmd_type op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         if (req_offering) req_bus.valid <= 1'b0;
         req_offering = 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= op;
      req_bus.item_id       <= id;
      req_bus.item_priority <= prio;
      req_offering = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      awaited_results.push_back(predict_step(op, id, prio));
   endtask

   task automatic stop_req();
      if (req_offering) req_bus.valid <= 1'b0;
      req_offering = 1'b0;
   endtask

   // Sender stays quiet until every pending result has come back
   task automatic wait_drained();
      stop_req();
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // Random insert or remove; a narrow span forces many equal priorities
   task automatic send_random(int insert_pct, bit narrow);
      logic [PRIO_W-1:0] prio;
      cmd_type           op;
      prio = narrow ? PRIO_W'($urandom_range(0, 3) * 85) : PRIO_W'($urandom_range(0, 255));
      op   = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      send_item(op, ID_W'($urandom_range(0, 255)), prio);
   endtask

   // Remove on empty, field extremes, and first-in order among equal priorities
   task automatic test_empty_and_order();
      send_item(CMD_REMOVE, 8'hFF, 8'hFF);
      send_item(CMD_INSERT, 8'hFF, 8'h00);
      send_item(CMD_INSERT, 8'h00, 8'hFF);
      send_item(CMD_INSERT, 8'h3C, 8'h80);
      send_item(CMD_INSERT, 8'hC3, 8'h80);
      repeat (4) send_item(CMD_REMOVE, 8'h00, 8'h00);
      send_item(CMD_REMOVE, 8'h5A, 8'hA5);
   endtask

   // Fill the store with ties, then push one more that must be dropped
   task automatic test_full_store();
      for (int k = 0; k < QUEUE_DEPTH; k++)
         send_item(CMD_INSERT, ID_W'(k * 17), PRIO_W'((k * 5) % 7));
      send_item(CMD_INSERT, 8'hFF, 8'h00);
   endtask

   // Long mixed run swinging between full and empty
   task automatic test_random_mix();
      int  insert_pct;
      bit  narrow;
      for (int seg = 0; seg < 15; seg++) begin
         case ($urandom_range(0, 2))
            0: begin
               insert_pct = 80;
            end
            1: begin
               insert_pct = 20;
            end
            default: begin
               insert_pct = 50;
            end
         endcase
         narrow      = $urandom_range(0, 1);
         req_idle_on = ($urandom_range(0, 2) != 0);
         rsp_idle_on = ($urandom_range(0, 2) != 0);
         repeat (100) send_random(insert_pct, narrow);
      end
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      wait_drained();
      req_idle_on     = 1'b0;
      rsp_hold_cycles = LONG_HOLD;
      repeat (40) send_random(60, 1'b1);
      wait_drained();
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_full_rate();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (120) send_random(75, 1'b1);
      repeat (130) send_random(50, 1'b0);
      repeat (130) send_random(25, 1'b1);
   endtask

   // Result receiver: random stall bursts, or one long hold when requested
   initial begin
      int n;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with nothing pending, expected none, actual id %0d",
                     $time, rsp_bus.out_id);
         end else begin
            want = awaited_results.pop_front();
            check_field("out_valid", want.out_valid, rsp_bus.out_valid);
            check_field("out_id", want.out_id, rsp_bus.out_id);
            check_field("out_priority", want.out_priority, rsp_bus.out_priority);
            check_field("status", want.status, rsp_bus.status);
            check_field("occupancy", want.occupancy, rsp_bus.occupancy);
         end
      end
   end

   // Watchdog on cycles where neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.cmd           <= CMD_INSERT;
      req_bus.item_id       <= '0;
      req_bus.item_priority <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_order();
      test_full_store();
      test_random_mix();
      test_backpressure();
      test_full_rate();

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/smpq_pkg.sv
hdl/smpq_if.sv
hdl/smpq_store.sv
hdl/stable_min_priority_queue.sv
sim/stable_min_priority_queue_tb.sv
